>>> rtl/lbpe_pkg.sv
`default_nettype none

package lbpe_pkg;

    localparam int CHANNELS = 8;
    localparam int PIN_W    = 3;
    localparam int CODE_W   = 8;
    localparam int CNT_W    = 8;
    localparam int FREQ_W   = 3;
    localparam int PER_W    = 9;
    localparam int LED_W    = 8;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [CODE_W-1:0] CODE_ALL_ON = 8'hff;
    localparam logic [CODE_W-1:0] CODE_OFF    = 8'h00;

    localparam logic [0:0] ACT_TICK = 1'b0;
    localparam logic [0:0] ACT_SET  = 1'b1;

    // Periods that are not powers of two, reduced by reciprocal multiply.
    localparam logic [PER_W-1:0] MOD_A   = 9'd43;
    localparam logic [8:0]       RECIP_A = 9'd381;
    localparam int               SHIFT_A = 14;
    localparam logic [PER_W-1:0] MOD_B   = 9'd22;
    localparam logic [8:0]       RECIP_B = 9'd372;
    localparam int               SHIFT_B = 13;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  on_cnt;
        logic [CNT_W-1:0]  off_cnt;
        logic [FREQ_W-1:0] freq;    // zero marks a constant channel
    } chan_entry_t;

    function automatic logic [PER_W-1:0] period_of(input logic [FREQ_W-1:0] freq);
        logic [PER_W-1:0] p;
        case (freq)
            3'd1:    p = 9'd256;
            3'd2:    p = 9'd128;
            3'd3:    p = 9'd64;
            3'd4:    p = 9'd43;
            3'd5:    p = 9'd32;
            3'd6:    p = 9'd22;
            3'd7:    p = 9'd16;
            default: p = 9'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lbpe_in_if.sv
`default_nettype none

interface lbpe_in_if;
    import lbpe_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [PIN_W-1:0]  pin;
    logic [CODE_W-1:0] code;

    modport source (output valid, output action, output pin, output code, input ready);
    modport sink (input valid, input action, input pin, input code, output ready);
endinterface

`default_nettype wire

>>> rtl/lbpe_out_if.sv
`default_nettype none

interface lbpe_out_if;
    import lbpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [LED_W-1:0] leds;
    logic             timer_on;

    modport source (output valid, output leds, output timer_on, input ready);
    modport sink (input valid, input leds, input timer_on, output ready);
endinterface

`default_nettype wire

>>> rtl/lbpe_derive.sv
`default_nettype none

module lbpe_derive (
    input  wire logic [lbpe_pkg::CODE_W-1:0] code,
    output lbpe_pkg::chan_entry_t            entry,
    output logic                             blinks,
    output logic                             level
);
    import lbpe_pkg::*;

    logic [PER_W-1:0] m;
    logic [PER_W:0]   m3;
    logic [PER_W-1:0] offset;
    logic [PER_W-1:0] duration;
    logic [PER_W:0]   sum;
    logic [PER_W:0]   wrapped;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;

    assign blinks = (code != CODE_ALL_ON) && (code[FREQ_W-1:0] != '0);
    assign level  = (code != CODE_OFF) && (code != CODE_ALL_ON);

    assign m  = period_of(code[FREQ_W-1:0]);
    assign m3 = {m, 1'b0} + {1'b0, m};

    always_comb
    begin
        case (code[4:3])
            2'd0: offset = '0;
            2'd1: offset = m >> 2;
            2'd2: offset = m >> 1;
            2'd3: offset = PER_W'(m3 >> 2);
        endcase
        case (code[6:5])
            2'd0: duration = m >> 3;
            2'd1: duration = m >> 2;
            2'd2: duration = PER_W'(m3 >> 3);
            2'd3: duration = m >> 1;
        endcase
    end

    // offset + duration stays below twice the period: one subtract wraps it
    assign sum     = {1'b0, offset} + {1'b0, duration};
    assign wrapped = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
    assign a       = offset[CNT_W-1:0];
    assign b       = wrapped[CNT_W-1:0];

    always_comb
    begin
        entry.code = code;
        if (blinks)
        begin
            entry.freq    = code[FREQ_W-1:0];
            entry.on_cnt  = code[7] ? b : a;
            entry.off_cnt = code[7] ? a : b;
        end
        else
        begin
            entry.freq    = '0;
            entry.on_cnt  = {{(CNT_W-1){1'b0}}, level};
            entry.off_cnt = {{(CNT_W-1){1'b0}}, level};
        end
    end

endmodule

`default_nettype wire

>>> rtl/led_blink_pattern_engine_unit.sv
`default_nettype none

// LED blink pattern engine, eight channels.
// item channel: action 1 stores code for pin; action 0 is a timer tick.
// result channel: one transaction per item, carrying the LED levels after
// the item and whether the blink tick timer is running.
// Channel state (code, on/off counts, frequency) lives in an 8-entry
// memory with a registered read port; a set reads the entry, compares and
// writes it back in the next cycle if it changed. A tick reduces the counter
// modulo 43 and 22 once (multiply state, then subtract state), then visits
// the channels one per cycle. A tick while the timer is stopped goes
// straight to the result. One item is in work at a time; the next is
// accepted at the earliest in the cycle after the result is loaded.
// Reset clears the levels, the timer, the counter and the entry valid
// bits, so every channel reads as code 0 (off, constant). No clearing pass.
// If the receiver stalls, the result register holds and the engine waits in
// its done state, accepting no new item until the register frees.
module led_blink_pattern_engine_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbpe_in_if.sink    item,
    lbpe_out_if.source result
);
    import lbpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_TICK_MUL,
        ST_TICK_SUB,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CODE_W-1:0] code_reg;
    logic [PIN_W-1:0]  pin_reg;
    logic [CNT_W-1:0]  tick_count_reg;
    logic [CHANNELS-1:0] blink_mask_reg;
    logic [CHANNELS-1:0] levels_reg;
    logic [CHANNELS-1:0] entry_valid_reg;
    logic              timer_running_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [16:0]       prod_a_reg;
    logic [16:0]       prod_b_reg;
    logic [CNT_W-1:0]  rem_a_reg;
    logic [CNT_W-1:0]  rem_b_reg;
    logic              out_valid_reg;
    logic [LED_W-1:0]  out_leds_reg;
    logic              out_timer_reg;

    chan_entry_t       mem [CHANNELS];
    chan_entry_t       rd_data_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;

    chan_entry_t       cur;
    chan_entry_t       new_entry;
    logic              new_blinks;
    logic              new_level;
    logic              pin_ok;
    logic              changed;
    logic [CHANNELS-1:0] mask_next;
    logic              accept;
    logic              out_load;

    logic [PER_W-1:0]  per;
    logic [CNT_W-1:0]  rem_a_fix;
    logic [CNT_W-1:0]  rem_b_fix;
    logic [CNT_W-1:0]  phase_cnt;
    logic [2:0]        q_a;
    logic [3:0]        q_b;

    lbpe_derive u_derive (
        .code   (code_reg),
        .entry  (new_entry),
        .blinks (new_blinks),
        .level  (new_level)
    );

    assign accept       = item.valid && item.ready;
    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.leds     = out_leds_reg;
    assign result.timer_on = out_timer_reg;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    assign cur     = rd_valid_reg ? rd_data_reg : '0;
    assign pin_ok  = ({1'b0, pin_reg} < (PIN_W + 1)'(CHANNELS));
    assign changed = pin_ok && (code_reg != cur.code);
    assign mem_we  = (state_reg == ST_SET_WR) && changed;

    always_comb
    begin
        mask_next = blink_mask_reg;
        mask_next[IDX_W'(pin_reg)] = new_blinks;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:     rd_addr = IDX_W'(item.pin);
            ST_SCAN:     rd_addr = idx_reg + IDX_W'(1);
            default:     rd_addr = '0;
        endcase
    end

    // quotient estimates can be one low: a single subtract corrects them
    assign q_a       = prod_a_reg[SHIFT_A +: 3];
    assign q_b       = prod_b_reg[SHIFT_B +: 4];
    assign rem_a_fix = (rem_a_reg >= CNT_W'(MOD_A)) ? (rem_a_reg - CNT_W'(MOD_A)) : rem_a_reg;
    assign rem_b_fix = (rem_b_reg >= CNT_W'(MOD_B)) ? (rem_b_reg - CNT_W'(MOD_B)) : rem_b_reg;
    assign per       = period_of(cur.freq);

    always_comb
    begin
        if (per == MOD_A)
            phase_cnt = rem_a_fix;
        else if (per == MOD_B)
            phase_cnt = rem_b_fix;
        else
            phase_cnt = tick_count_reg & CNT_W'(per - PER_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[IDX_W'(pin_reg)] <= new_entry;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            tick_count_reg    <= '0;
            blink_mask_reg    <= '0;
            levels_reg        <= '0;
            entry_valid_reg   <= '0;
            timer_running_reg <= 1'b0;
            idx_reg           <= '0;
            rd_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= entry_valid_reg[rd_addr];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pin_reg  <= item.pin;
                        code_reg <= item.code;
                        if (item.action == ACT_SET)
                            state_reg <= ST_SET_WR;
                        else if (timer_running_reg)
                        begin
                            tick_count_reg <= tick_count_reg + CNT_W'(1);
                            state_reg      <= ST_TICK_MUL;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_SET_WR:
                begin
                    if (changed)
                    begin
                        entry_valid_reg[IDX_W'(pin_reg)] <= 1'b1;
                        blink_mask_reg <= mask_next;
                        if (!timer_running_reg)
                        begin
                            if (new_blinks)
                                timer_running_reg <= 1'b1;
                        end
                        else if (mask_next == '0)
                            timer_running_reg <= 1'b0;
                        if (!new_blinks)
                            levels_reg[IDX_W'(pin_reg)] <= new_level;
                    end
                    state_reg <= ST_DONE;
                end
                ST_TICK_MUL:
                begin
                    prod_a_reg <= 17'(tick_count_reg) * 17'(RECIP_A);
                    prod_b_reg <= 17'(tick_count_reg) * 17'(RECIP_B);
                    state_reg  <= ST_TICK_SUB;
                end
                ST_TICK_SUB:
                begin
                    rem_a_reg <= tick_count_reg - CNT_W'(q_a) * CNT_W'(MOD_A);
                    rem_b_reg <= tick_count_reg - CNT_W'(q_b) * CNT_W'(MOD_B);
                    idx_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cur.freq != '0)
                    begin
                        if (phase_cnt == cur.on_cnt)
                            levels_reg[idx_reg] <= 1'b1;
                        else if (phase_cnt == cur.off_cnt)
                            levels_reg[idx_reg] <= 1'b0;
                    end
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(CHANNELS - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_leds_reg  <= LED_W'(levels_reg);
                        out_timer_reg <= timer_running_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // timer runs exactly while some channel blinks
    a_timer_mask: assert property (@(posedge clk) disable iff (!rst_n)
        timer_running_reg == (blink_mask_reg != '0))
        else $error("timer state disagrees with blinking mask");

    // counter only advances on an accepted tick transaction
    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_count_reg != $past(tick_count_reg)) |->
            ($past(accept) && ($past(item.action) == ACT_TICK)))
        else $error("tick counter moved without a tick");

    // channel scan happens only with the timer running
    a_scan_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> timer_running_reg)
        else $error("channel scan while timer stopped");

endmodule

`default_nettype wire

>>> dv/tb.sv
module tb;
    import lbpe_pkg::*;

    logic clk;
    logic rst_n;

    lbpe_in_if  item_if ();
    lbpe_out_if result_if ();

    led_blink_pattern_engine_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             timer_on;
    } led_view_t;

    class led_blink_scoreboard;
        logic [CODE_W-1:0]   chan_code [CHANNELS];
        logic [CNT_W-1:0]    on_cnt [CHANNELS];
        logic [CNT_W-1:0]    off_cnt [CHANNELS];
        int                  period [CHANNELS];    // 0: steady level, no blinking
        logic [CHANNELS-1:0] blink_mask;
        logic                timer_run;
        logic [CNT_W-1:0]    tick_cnt;
        logic [LED_W-1:0]    levels;
        led_view_t           expected_levels [$];
        int                  errors;

        function new();
            for (int n = 0; n < CHANNELS; n++)
            begin
                chan_code[n] = CODE_OFF;
                on_cnt[n]    = '0;
                off_cnt[n]   = '0;
                period[n]    = 0;
            end
            blink_mask = '0;
            timer_run  = 1'b0;
            tick_cnt   = '0;
            levels     = '0;
            errors     = 0;
        endfunction

        function bit blinks(logic [CODE_W-1:0] c);
            return (c != CODE_ALL_ON) && (c[2:0] != 3'd0);
        endfunction

        function int blink_period(logic [2:0] freq);
            case (freq)
                3'd1:    return 256;
                3'd2:    return 128;
                3'd3:    return 64;
                3'd4:    return 43;
                3'd5:    return 32;
                3'd6:    return 22;
                3'd7:    return 16;
                default: return 0;
            endcase
        endfunction

        function bit set_code(logic [PIN_W-1:0] pin, logic [CODE_W-1:0] c);
            int m;
            int offset;
            int span;
            int a;
            int b;
            if (c == chan_code[pin])
                return 1'b0;
            chan_code[pin]  = c;
            blink_mask[pin] = blinks(c);
            if (!timer_run)
            begin
                if (blinks(c))
                    timer_run = 1'b1;
            end
            else if (blink_mask == '0)
                timer_run = 1'b0;
            if (!blinks(c))
            begin
                // steady: off for all-zero and all-one codes, on otherwise
                levels[pin]  = (c != CODE_OFF) && (c != CODE_ALL_ON);
                on_cnt[pin]  = CNT_W'(levels[pin]);
                off_cnt[pin] = CNT_W'(levels[pin]);
                period[pin]  = 0;
                return 1'b1;
            end
            m      = blink_period(c[2:0]);
            offset = (int'(c[4:3]) * m) / 4;
            span   = ((int'(c[6:5]) + 1) * m) / 8;
            a      = offset % 256;
            b      = ((offset + span) % m) % 256;
            if (c[7])
            begin
                on_cnt[pin]  = CNT_W'(b);
                off_cnt[pin] = CNT_W'(a);
            end
            else
            begin
                on_cnt[pin]  = CNT_W'(a);
                off_cnt[pin] = CNT_W'(b);
            end
            period[pin] = m;
            return 1'b1;
        endfunction

        function bit advance_tick();
            int phase_pos;
            if (!timer_run)
                return 1'b0;
            tick_cnt = tick_cnt + 1'b1;
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (period[n] != 0)
                begin
                    phase_pos = int'(tick_cnt) % period[n];
                    // on wins when both counts match
                    if (phase_pos == int'(on_cnt[n]))
                        levels[n] = 1'b1;
                    else if (phase_pos == int'(off_cnt[n]))
                        levels[n] = 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Returns whether the transaction changed anything.
        function bit note_item(logic action, logic [PIN_W-1:0] pin, logic [CODE_W-1:0] c);
            bit changed;
            if (action == ACT_SET)
                changed = set_code(pin, c);
            else
                changed = advance_tick();
            expected_levels.push_back({levels, timer_run});
            return changed;
        endfunction

        function void check_result(logic [LED_W-1:0] leds, logic timer_on);
            led_view_t want;
            if (expected_levels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction: leds %h timer_on %b",
                         $time, leds, timer_on);
                return;
            end
            want = expected_levels.pop_front();
            if (leds !== want.leds)
            begin
                errors++;
                $display("%0t: leds mismatch: expected %h actual %h", $time, want.leds, leds);
            end
            if (timer_on !== want.timer_on)
            begin
                errors++;
                $display("%0t: timer_on mismatch: expected %b actual %b",
                         $time, want.timer_on, timer_on);
            end
        endfunction
    endclass

    led_blink_scoreboard led_model = new();

    int send_gap_max = 7;
    int items_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [CODE_W-1:0] steady_code();
        logic [CODE_W-1:0] r;
        r = CODE_W'($urandom);
        if (r[1:0] == 2'd0)
            return CODE_ALL_ON;
        return {r[7:3], 3'b000};
    endfunction

    task automatic send_item(input logic action, input logic [PIN_W-1:0] pin,
                             input logic [CODE_W-1:0] c);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid  <= 1'b1;
        item_if.action <= action;
        item_if.pin    <= pin;
        item_if.code   <= c;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        void'(led_model.note_item(action, pin, c));
        items_sent++;
    endtask

    // result side: random back-pressure with stall-free stretches
    initial
    begin
        int stall;
        int stall_max;
        int taken;
        result_if.ready = 1'b0;
        stall_max = 7;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 40 == 0)
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
            led_model.check_result(result_if.leds, result_if.timer_on);
            taken++;
        end
    end

    initial
    begin
        int kind;
        int sent;
        logic [PIN_W-1:0] pin;
        item_if.valid  = 1'b0;
        item_if.action = ACT_TICK;
        item_if.pin    = '0;
        item_if.code   = CODE_OFF;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(ACT_TICK, 3'd0, CODE_OFF);       // timer stopped: ignored
        send_item(ACT_SET, 3'd0, CODE_OFF);        // same as reset code
        send_item(ACT_SET, 3'd1, CODE_ALL_ON);     // all-ones code is off
        send_item(ACT_SET, 3'd2, 8'h80);           // freq 0 with invert: on
        send_item(ACT_SET, 3'd3, 8'h78);
        send_item(ACT_SET, 3'd0, 8'h01);           // first blinker starts timer
        send_item(ACT_SET, 3'd0, 8'h01);
        send_item(ACT_SET, 3'd4, 8'h7f);
        send_item(ACT_SET, 3'd5, 8'he4);
        send_item(ACT_SET, 3'd6, 8'h56);
        send_item(ACT_SET, 3'd7, 8'h8b);
        send_item(ACT_SET, 3'd1, 8'h2d);
        send_item(ACT_SET, 3'd2, 8'h32);
        repeat (4) send_item(ACT_TICK, 3'd7, CODE_ALL_ON);
        send_item(ACT_SET, 3'd0, CODE_OFF);
        send_item(ACT_SET, 3'd1, CODE_ALL_ON);
        send_item(ACT_SET, 3'd2, 8'h08);
        send_item(ACT_SET, 3'd4, CODE_OFF);
        send_item(ACT_SET, 3'd5, 8'h80);
        send_item(ACT_SET, 3'd6, 8'hf8);
        send_item(ACT_SET, 3'd7, CODE_OFF);        // last blinker gone: timer stops
        send_item(ACT_TICK, 3'd5, 8'h5a);

        sent = 0;
        while (items_sent < 850)
        begin
            if (sent % 40 == 0)
                send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            kind = $urandom_range(0, 99);
            pin  = PIN_W'($urandom_range(0, CHANNELS - 1));
            if (kind < 62)
                send_item(ACT_TICK, pin, CODE_W'($urandom));
            else if (kind < 84)
                send_item(ACT_SET, pin, CODE_W'($urandom));
            else if (kind < 90)
                send_item(ACT_SET, pin, led_model.chan_code[pin]);
            else if (kind < 96)
                send_item(ACT_SET, pin, steady_code());
            else
            begin
                // drop every channel to a steady level so the timer stops
                for (int p = 0; p < CHANNELS; p++)
                    send_item(ACT_SET, PIN_W'(p), steady_code());
            end
            sent++;
        end
        item_if.valid <= 1'b0;

        while (led_model.expected_levels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (led_model.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
